// File: src/gdr_pkg.sv
package gdr_pkg;

  localparam logic [19:0] DIST_MAX = 20'hFFFFF;
  localparam logic [12:0] FRAC_ONE = 13'd4096;
  localparam int          DIV_BITS = 27;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIVX  = 8'b0000_0010,
    S_DIVY  = 8'b0000_0100,
    S_INITX = 8'b0000_1000,
    S_INITY = 8'b0001_0000,
    S_STEP  = 8'b0010_0000,
    S_CRX   = 8'b0100_0000,
    S_CRY   = 8'b1000_0000
  } gdr_state_t;

  typedef struct packed {
    logic        done;
    logic [19:0] quo;
  } gdr_div_res_t;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_LEFT   = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

endpackage

// File: src/gdr_recip.sv
module gdr_recip (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [15:0]           divisor,
  output gdr_pkg::gdr_div_res_t res
);

  logic                          busy_r;
  logic [4:0]                    cnt_r;
  logic [15:0]                   rem_r;
  logic [gdr_pkg::DIV_BITS-1:0]  quo_r;
  logic [15:0]                   dvs_r;
  logic                          done_r;
  logic [16:0]                   trial;
  logic                          ge;

  // restoring division of 2^26 by divisor, one quotient bit per cycle
  assign trial = {rem_r, (cnt_r == 5'(gdr_pkg::DIV_BITS - 1))};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(gdr_pkg::DIV_BITS - 1);
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
        quo_r <= {quo_r[gdr_pkg::DIV_BITS-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // a zero divisor yields all ones and saturates
  assign res.done = done_r;
  assign res.quo  = (quo_r[gdr_pkg::DIV_BITS-1:20] != '0) ? gdr_pkg::DIST_MAX : quo_r[19:0];

endmodule

// File: src/grid_dda_ray_caster_core.sv
// grid dda ray caster: a map write leaves busy low
// a ray that starts inside the map first runs two reciprocals in one shared bit-serial
// divider and two side-distance multiplies, then each crossing goes through the single
// shared multiplier; one beat is strobed per crossing
// throughput: one ray at a time, next start taken once busy drops
// synchronous active-low reset clears the sequencer, then a pass over all 256 cells clears the wall map
module grid_dda_ray_caster_core #(
  parameter int MAP_COLS  = 16,
  parameter int MAP_ROWS  = 16,
  parameter int MAX_STEPS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [3:0]         in_cell_col,
  input  logic [3:0]         in_cell_row,
  input  logic               in_cell_wall,
  input  logic [15:0]        in_pos_x,
  input  logic [15:0]        in_pos_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  output logic               out_valid,
  output logic [15:0]        out_cross_x,
  output logic [15:0]        out_cross_y,
  output logic               out_side,
  output logic [19:0]        out_distance,
  output logic [3:0]         out_entered_col,
  output logic [3:0]         out_entered_row,
  output logic [1:0]         out_status,
  output logic               out_last
);

  localparam int SW   = $clog2(MAX_STEPS);
  // upper clamp of a crossing coordinate, Q4.12
  localparam int UP_X = ((MAP_COLS * 4096 > 65536) ? 65536 : MAP_COLS * 4096) - 1;
  localparam int UP_Y = ((MAP_ROWS * 4096 > 65536) ? 65536 : MAP_ROWS * 4096) - 1;

  gdr_pkg::gdr_state_t state_r, state_nxt;

  // ray registers
  logic [15:0]        px_r, py_r;
  logic signed [15:0] dx_r, dy_r;
  logic [19:0]        dlx_r, dly_r;
  logic [19:0]        sx_r, sy_r;
  logic [19:0]        t_r;
  logic signed [7:0]  col_r, row_r;
  logic               side_r;
  logic [SW-1:0]      cnt_r;
  logic [15:0]        cx_r;

  // wall bitmap, only the 16x16 cells the write port can reach
  logic               wall_r [256];
  logic               wall_rd_r;

  // clearing pass over the bitmap after reset
  logic               clr_act_r;
  logic [7:0]         clr_cnt_r;

  // shared reciprocal unit
  logic                  div_go;
  logic [15:0]           div_dvs;
  gdr_pkg::gdr_div_res_t div_res;

  logic        accept;
  logic        start_in_map;
  logic [16:0] abs_x, abs_y;
  logic [12:0] fx, fy;

  assign accept       = start && !busy;
  assign busy         = (state_r != gdr_pkg::S_IDLE) || clr_act_r;
  assign start_in_map = (32'(in_pos_x[15:12]) < MAP_COLS) && (32'(in_pos_y[15:12]) < MAP_ROWS);
  assign abs_x        = dx_r[15] ? 17'(-{dx_r[15], dx_r}) : {1'b0, dx_r};
  assign abs_y        = dy_r[15] ? 17'(-{dy_r[15], dy_r}) : {1'b0, dy_r};

  // distance to the first grid line along each axis, Q1.12
  assign fx = (dx_r > 0) ? 13'(gdr_pkg::FRAC_ONE - {1'b0, px_r[11:0]}) : {1'b0, px_r[11:0]};
  assign fy = (dy_r > 0) ? 13'(gdr_pkg::FRAC_ONE - {1'b0, py_r[11:0]}) : {1'b0, py_r[11:0]};

  // divider launches: x right after accept, y when x finishes
  always_comb begin
    div_go  = 1'b0;
    div_dvs = abs_x[15:0];
    case (state_r)
      gdr_pkg::S_DIVX: begin
        div_go  = div_res.done;
        div_dvs = abs_y[15:0];
      end
      default: ;
    endcase
  end

  // the x reciprocal starts on the cycle after accept
  logic div_kick_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_kick_r <= 1'b0;
    end else begin
      div_kick_r <= accept && in_mode && start_in_map;
    end
  end

  logic [15:0] div_dvs_mux;
  logic        div_go_mux;
  assign div_go_mux  = div_go || div_kick_r;
  assign div_dvs_mux = div_kick_r ? abs_x[15:0] : div_dvs;

  gdr_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go_mux),
    .divisor (div_dvs_mux),
    .res     (div_res)
  );

  // single shared multiplier
  logic signed [16:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [37:0] mul_p;

  always_comb begin
    case (state_r)
      gdr_pkg::S_INITX: begin
        mul_a = {4'b0, fx};
        mul_b = {1'b0, dlx_r};
      end
      gdr_pkg::S_INITY: begin
        mul_a = {4'b0, fy};
        mul_b = {1'b0, dly_r};
      end
      gdr_pkg::S_CRX: begin
        mul_a = {dx_r[15], dx_r};
        mul_b = {1'b0, t_r};
      end
      default: begin
        mul_a = {dy_r[15], dy_r};
        mul_b = {1'b0, t_r};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // side distance from product, floor >> 12, saturated
  logic [19:0] init_sd;
  assign init_sd = (mul_p[37:32] != '0) ? gdr_pkg::DIST_MAX : mul_p[31:12];

  // crossing point: pos + floor(dir*t / 2^14), clamped
  logic signed [25:0] cross_v;
  logic [15:0]        cross_pos;
  logic [15:0]        cross_clamped;

  assign cross_pos = (state_r == gdr_pkg::S_CRX) ? px_r : py_r;
  assign cross_v   = $signed({10'b0, cross_pos}) + 26'(mul_p >>> 14);

  always_comb begin
    logic signed [25:0] up;
    up = (state_r == gdr_pkg::S_CRX) ? 26'(UP_X) : 26'(UP_Y);
    if (cross_v < 0) begin
      cross_clamped = '0;
    end else if (cross_v > up) begin
      cross_clamped = up[15:0];
    end else begin
      cross_clamped = cross_v[15:0];
    end
  end

  // dda step: take the smaller side distance
  logic        take_x;
  logic [20:0] sum_x, sum_y;
  assign take_x = sx_r < sy_r;
  assign sum_x  = {1'b0, sx_r} + {1'b0, dlx_r};
  assign sum_y  = {1'b0, sy_r} + {1'b0, dly_r};

  // classification of the entered cell
  logic cell_in_map, cell_wall, step_last;
  logic [1:0] step_status;
  assign cell_in_map = (col_r >= 0) && (32'(col_r) < MAP_COLS) &&
                       (row_r >= 0) && (32'(row_r) < MAP_ROWS);
  assign cell_wall   = cell_in_map && (col_r < 8'sd16) && (row_r < 8'sd16) && wall_rd_r;

  always_comb begin
    step_status = gdr_pkg::ST_NORMAL;
    step_last   = 1'b0;
    if (!cell_in_map) begin
      step_status = gdr_pkg::ST_LEFT;
      step_last   = 1'b1;
    end else if (cell_wall) begin
      step_last   = 1'b1;
    end else if (cnt_r == SW'(MAX_STEPS - 1)) begin
      step_status = gdr_pkg::ST_LIMIT;
      step_last   = 1'b1;
    end
  end

  // entered cell clamped into the map
  logic [3:0] col_clamp, row_clamp;
  always_comb begin
    if (col_r < 0) begin
      col_clamp = '0;
    end else if (32'(col_r) >= MAP_COLS) begin
      col_clamp = 4'(MAP_COLS - 1);
    end else begin
      col_clamp = col_r[3:0];
    end
    if (row_r < 0) begin
      row_clamp = '0;
    end else if (32'(row_r) >= MAP_ROWS) begin
      row_clamp = 4'(MAP_ROWS - 1);
    end else begin
      row_clamp = row_r[3:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdr_pkg::S_IDLE: begin
        if (accept && in_mode) begin
          state_nxt = start_in_map ? gdr_pkg::S_DIVX : gdr_pkg::S_CRX;
        end
      end
      gdr_pkg::S_DIVX:  if (div_res.done) state_nxt = gdr_pkg::S_DIVY;
      gdr_pkg::S_DIVY:  if (div_res.done) state_nxt = gdr_pkg::S_INITX;
      gdr_pkg::S_INITX: state_nxt = gdr_pkg::S_INITY;
      gdr_pkg::S_INITY: state_nxt = gdr_pkg::S_STEP;
      gdr_pkg::S_STEP:  state_nxt = gdr_pkg::S_CRX;
      gdr_pkg::S_CRX:   state_nxt = gdr_pkg::S_CRY;
      gdr_pkg::S_CRY:   state_nxt = step_last ? gdr_pkg::S_IDLE : gdr_pkg::S_STEP;
      default:          state_nxt = gdr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gdr_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == gdr_pkg::S_CRY);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gdr_pkg::S_IDLE: begin
        if (accept) begin
          px_r   <= in_pos_x;
          py_r   <= in_pos_y;
          dx_r   <= in_dir_x;
          dy_r   <= in_dir_y;
          col_r  <= {4'b0, in_pos_x[15:12]};
          row_r  <= {4'b0, in_pos_y[15:12]};
          t_r    <= '0;
          side_r <= 1'b0;
          cnt_r  <= '0;
        end
      end
      gdr_pkg::S_DIVX: if (div_res.done) dlx_r <= div_res.quo;
      gdr_pkg::S_DIVY: if (div_res.done) dly_r <= div_res.quo;
      gdr_pkg::S_INITX: sx_r <= init_sd;
      gdr_pkg::S_INITY: sy_r <= init_sd;
      gdr_pkg::S_STEP: begin
        if (take_x) begin
          t_r    <= sx_r;
          sx_r   <= sum_x[20] ? gdr_pkg::DIST_MAX : sum_x[19:0];
          col_r  <= (dx_r > 0) ? col_r + 8'sd1 : col_r - 8'sd1;
          side_r <= 1'b0;
        end else begin
          t_r    <= sy_r;
          sy_r   <= sum_y[20] ? gdr_pkg::DIST_MAX : sum_y[19:0];
          row_r  <= (dy_r > 0) ? row_r + 8'sd1 : row_r - 8'sd1;
          side_r <= 1'b1;
        end
      end
      gdr_pkg::S_CRX: cx_r <= cross_clamped;
      gdr_pkg::S_CRY: begin
        out_cross_x     <= cx_r;
        out_cross_y     <= cross_clamped;
        out_side        <= side_r;
        out_distance    <= t_r;
        out_entered_col <= col_clamp;
        out_entered_row <= row_clamp;
        out_status      <= step_status;
        out_last        <= step_last;
        cnt_r           <= cnt_r + SW'(1);
      end
      default: ;
    endcase
  end

  // one cell cleared per cycle after reset, busy held high meanwhile
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_act_r) begin
      clr_cnt_r <= clr_cnt_r + 8'd1;
      if (clr_cnt_r == 8'hFF) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  // wall map: write on mode-0 beats, registered read of the entered cell
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      wall_r[clr_cnt_r] <= 1'b0;
    end else if (accept && !in_mode &&
                 (32'(in_cell_col) < MAP_COLS) && (32'(in_cell_row) < MAP_ROWS)) begin
      wall_r[{in_cell_row, in_cell_col}] <= in_cell_wall;
    end
  end

  always_ff @(posedge clk) begin
    wall_rd_r <= wall_r[{row_r[3:0], col_r[3:0]}];
  end

  // a final beat always leaves the block idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("last beat while still busy");

  // a beat that is not final keeps the ray walking
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("ray stopped without a final beat");

  // a ray start raises busy
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode |=> busy)
    else $error("ray accepted but not busy");

  // leaving the map or hitting the limit ends the ray
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != gdr_pkg::ST_NORMAL) |-> out_last)
    else $error("abnormal status on a non-final beat");

endmodule

// File: dv/testbench.sv
module testbench;

  localparam int NCOLS = 16;
  localparam int NROWS = 16;
  localparam int NSTEPS = 64;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  col;
    logic [3:0]  row;
    logic        wall;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] dx;
    logic [15:0] dy;
  } ray_cmd_t;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic        side;
    logic [19:0] distance;
    logic [3:0]  ecol;
    logic [3:0]  erow;
    logic [1:0]  status;
    logic        last;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [3:0] in_cell_col = '0, in_cell_row = '0;
  logic in_cell_wall = 1'b0;
  logic [15:0] in_pos_x = '0, in_pos_y = '0;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0;
  logic out_valid, out_side, out_last;
  logic [15:0] out_cross_x, out_cross_y;
  logic [19:0] out_distance;
  logic [3:0] out_entered_col, out_entered_row;
  logic [1:0] out_status;

  ray_cmd_t  pending_cmds[$];
  crossing_t expected_crossings[$];
  bit        wall_bits[NROWS*NCOLS];
  int        mismatches = 0;
  bit        stim_done = 0;

  always #1 clk = ~clk;

  grid_dda_ray_caster_core u_top (.*);

  // fixed-point helpers
  function automatic logic [19:0] recip_dist(int d);
    longint a, q;
    a = d < 0 ? -d : d;
    if (a == 0) return gdr_pkg::DIST_MAX;
    q = (64'd1 << 26) / a;
    return q > gdr_pkg::DIST_MAX ? gdr_pkg::DIST_MAX : q[19:0];
  endfunction

  function automatic logic [19:0] add_sat(logic [19:0] a, logic [19:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    return s > gdr_pkg::DIST_MAX ? gdr_pkg::DIST_MAX : s[19:0];
  endfunction

  function automatic logic [15:0] crossing_coord(int p, int d, longint t, int cells);
    longint prod, q, v, upper;
    prod = longint'(d) * t;
    q = prod >= 0 ? (prod >>> 14) : -(((-prod) + 16383) >>> 14);
    v = p + q;
    upper = longint'(cells) * 4096 - 1;
    if (upper > 65535) upper = 65535;
    if (v < 0) v = 0;
    if (v > upper) v = upper;
    return v[15:0];
  endfunction

  function automatic logic [3:0] edge_cell(int c, int n);
    if (c < 0) c = 0;
    if (c >= n) c = n - 1;
    return c[3:0];
  endfunction

  // work out every crossing a ray produces, or apply a map write
  task automatic predict_cast(ray_cmd_t c);
    int px, py, dx, dy, col, row, stx, sty, fx, fy, n;
    logic [19:0] dlx, dly, sx, sy, t;
    longint a;
    crossing_t e;
    bit out_of_map;
    if (c.mode == MODE_WRITE) begin
      wall_bits[c.row*NCOLS + c.col] = c.wall;
      return;
    end
    px = c.px; py = c.py;
    dx = $signed(c.dx); dy = $signed(c.dy);
    col = px >> 12; row = py >> 12;
    if (col >= NCOLS || row >= NROWS) begin
      e.cx = crossing_coord(px, 0, 0, NCOLS);
      e.cy = crossing_coord(py, 0, 0, NROWS);
      e.side = 0; e.distance = 0;
      e.ecol = edge_cell(col, NCOLS); e.erow = edge_cell(row, NROWS);
      e.status = gdr_pkg::ST_LEFT; e.last = 1;
      expected_crossings.push_back(e);
      return;
    end
    dlx = recip_dist(dx); dly = recip_dist(dy);
    stx = dx > 0 ? 1 : -1;
    sty = dy > 0 ? 1 : -1;
    fx = dx > 0 ? 4096 - (px & 4095) : (px & 4095);
    fy = dy > 0 ? 4096 - (py & 4095) : (py & 4095);
    a = (longint'(fx) * dlx) >> 12;
    sx = a > gdr_pkg::DIST_MAX ? gdr_pkg::DIST_MAX : a[19:0];
    a = (longint'(fy) * dly) >> 12;
    sy = a > gdr_pkg::DIST_MAX ? gdr_pkg::DIST_MAX : a[19:0];
    for (n = 0; n < NSTEPS; n++) begin
      if (sx < sy) begin
        t = sx; sx = add_sat(sx, dlx); col += stx; e.side = 0;
      end else begin
        t = sy; sy = add_sat(sy, dly); row += sty; e.side = 1;
      end
      out_of_map = col < 0 || col >= NCOLS || row < 0 || row >= NROWS;
      e.status = gdr_pkg::ST_NORMAL; e.last = 0;
      if (out_of_map) begin
        e.status = gdr_pkg::ST_LEFT; e.last = 1;
      end else if (wall_bits[row*NCOLS + col]) begin
        e.last = 1;
      end else if (n == NSTEPS - 1) begin
        e.status = gdr_pkg::ST_LIMIT; e.last = 1;
      end
      e.cx = crossing_coord(px, dx, t, NCOLS);
      e.cy = crossing_coord(py, dy, t, NROWS);
      e.distance = t;
      e.ecol = edge_cell(col, NCOLS); e.erow = edge_cell(row, NROWS);
      expected_crossings.push_back(e);
      if (e.last) break;
    end
  endtask

  function automatic ray_cmd_t make_write(int col, int row, bit w);
    ray_cmd_t c;
    c = '0;
    c.mode = MODE_WRITE; c.col = 4'(col); c.row = 4'(row); c.wall = w;
    c.px = 16'($urandom); c.py = 16'($urandom);
    c.dx = 16'($urandom); c.dy = 16'($urandom);
    return c;
  endfunction

  function automatic ray_cmd_t make_cast(int px, int py, int dx, int dy);
    ray_cmd_t c;
    c = '0;
    c.mode = MODE_CAST; c.px = 16'(px); c.py = 16'(py); c.dx = 16'(dx); c.dy = 16'(dy);
    c.col = 4'($urandom); c.row = 4'($urandom); c.wall = 1'($urandom);
    return c;
  endfunction

  function automatic int rand_dir();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16384;
      2: return -16384;
      3: return int'($urandom_range(0, 40)) - 20;  // tiny, saturates the reciprocal
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // stimulus: directed corners, a full map clear, then random map edits and rays
  initial begin
    int k;
    // corner walls at 0,0 and 15,15 (the latter cleared again) plus one inner wall at 5,8, extremes of cell fields
    pending_cmds.push_back(make_write(0, 0, 1));
    pending_cmds.push_back(make_write(15, 15, 1));
    pending_cmds.push_back(make_write(15, 15, 0));
    pending_cmds.push_back(make_write(5, 8, 1));
    // sparse map: most of these rays leave the map
    pending_cmds.push_back(make_cast(16'h8800, 16'h8800, 16384, 0));
    pending_cmds.push_back(make_cast(16'h8800, 16'h8800, -16384, 0));
    pending_cmds.push_back(make_cast(16'h8800, 16'h8800, 0, 16384));
    pending_cmds.push_back(make_cast(16'h8800, 16'h8800, 0, -16384));
    pending_cmds.push_back(make_cast(16'h0000, 16'h0000, 11585, 11585));
    pending_cmds.push_back(make_cast(16'hFFFF, 16'hFFFF, -11585, -11585));
    pending_cmds.push_back(make_cast(16'h8000, 16'h8000, 0, 0));
    pending_cmds.push_back(make_cast(16'h8123, 16'h4567, 1, -1));
    pending_cmds.push_back(make_cast(16'h2800, 16'h8800, 16384, 0));  // hits wall at 5,8
    pending_cmds.push_back(make_cast(16'h0800, 16'h0800, -16384, 300));  // starts in corner wall, leaves the map
    pending_cmds.push_back(make_cast(16'h4000, 16'h4000, -5, 7));
    // diagonal from near the origin crosses many cells before leaving the map
    pending_cmds.push_back(make_cast(16'h0010, 16'h0010, 16000, 16000));
    for (k = 0; k < 256; k++) pending_cmds.push_back(make_write(k % 16, k / 16, 0));
    // sparse random walls interleaved with random rays
    for (k = 0; k < 138; k++) begin
      if ($urandom_range(0, 3) == 0)
        pending_cmds.push_back(make_write($urandom, $urandom, $urandom_range(0, 4) == 0));
      else
        pending_cmds.push_back(make_cast($urandom, $urandom, rand_dir(), rand_dir()));
    end
    stim_done = 1;
  end

  // driver: one beat per command, random gap before each
  int gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    ray_cmd_t c;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // beat accepted this edge
      start <= 1'b0;
      gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    end else if (!start) begin
      if (sent == 20 && expected_crossings.size() != 0) begin
        // hold off until all crossings drained once
      end else if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        predict_cast(c);
        sent <= sent + 1;
        start <= 1'b1;
        in_mode <= c.mode; in_cell_col <= c.col; in_cell_row <= c.row;
        in_cell_wall <= c.wall; in_pos_x <= c.px; in_pos_y <= c.py;
        in_dir_x <= c.dx; in_dir_y <= c.dy;
      end
    end
  end

  // monitor: each strobed crossing against the oldest expected one
  always @(posedge clk) begin
    crossing_t got, want;
    if (rst_n && out_valid) begin
      got = {out_cross_x, out_cross_y, out_side, out_distance,
             out_entered_col, out_entered_row, out_status, out_last};
      if (expected_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected crossing %h", got);
      end else begin
        want = expected_crossings.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("crossing mismatch: exp x=%h y=%h s=%b d=%h c=%0d r=%0d st=%0d l=%b",
                   want.cx, want.cy, want.side, want.distance, want.ecol, want.erow,
                   want.status, want.last);
            $display(" | got x=%h y=%h s=%b d=%h c=%0d r=%0d st=%0d l=%b",
                     got.cx, got.cy, got.side, got.distance,
                     got.ecol, got.erow, got.status, got.last);
          end
        end
      end
    end
  end

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_cmds.size() != 0 || start) @(posedge clk);
    waited = 0;
    while ((expected_crossings.size() != 0 || busy) && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_crossings.size() == 0) begin
      $display("grid_dda_ray_caster_core regression: pass");
    end else begin
      $display("grid_dda_ray_caster_core regression: fail");
    end
    $finish;
  end

  // watchdog: ends a run that has not finished its 410 commands and the map clear in time
  initial begin
    #2000000;
    $display("grid_dda_ray_caster_core regression: fail");
    $finish;
  end

endmodule
